/* src/frame_rate_meter_core_macros.svh */
// Assertion helpers shared by the RTL files.
`ifndef FRAME_RATE_METER_CORE_MACROS_SVH
`define FRAME_RATE_METER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FRM_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame_rate_meter_core: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define FRM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame_rate_meter_core: next-cycle check failed");

`endif

/* src/frm_pkg.sv */
package frm_pkg;

  localparam int FRAME_COUNT_BITS_DEF = 24;
  localparam int FRACTION_BITS_DEF    = 8;

  localparam int ELAPSED_W = 40;
  localparam int RATE_W    = 32;
  localparam int WHOLE_W   = 25;
  localparam int WINDOW_W  = 24;
  localparam int SECS_W    = 32;
  localparam int MICROS_W  = 20;

  localparam logic [MICROS_W-1:0] MICROS_PER_SEC = 20'd1000000;
  localparam logic [WINDOW_W-1:0] WINDOW_RESET   = 24'd1000000;

  // Register word index, taken from paddr[2]
  localparam logic REG_WINDOW_US = 1'b0;

endpackage

/* src/frm_divider.sv */
`include "frame_rate_meter_core_macros.svh"

module frm_divider #(
  parameter int NUM_W = 52,
  parameter int DEN_W = frm_pkg::ELAPSED_W,
  parameter int QUO_W = frm_pkg::RATE_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] numer,
  input  logic [DEN_W-1:0] denom,
  output logic             done,
  output logic [QUO_W-1:0] quotient
);
  import frm_pkg::*;

  localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic             busy;
  logic [CNT_W-1:0] count;
  logic [NUM_W-1:0] num_sh;
  logic [DEN_W-1:0] rem;
  logic [QUO_W-1:0] quo;
  logic             ovf;

  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_diff;
  logic             fits;
  logic [DEN_W-1:0] rem_next;

  // One restoring step per cycle: shift in a numerator bit, try the subtract
  always_comb begin
    rem_sh   = {rem, num_sh[NUM_W-1]};
    fits     = (rem_sh >= {1'b0, denom});
    rem_diff = rem_sh - {1'b0, denom};
    rem_next = fits ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        count  <= CNT_W'(NUM_W - 1);
        num_sh <= numer;
        rem    <= '0;
        quo    <= '0;
        ovf    <= 1'b0;
      end else if (busy) begin
        num_sh <= num_sh << 1;
        rem    <= rem_next;
        quo    <= {quo[QUO_W-2:0], fits};
        // a quotient bit pushed past the top means saturation
        ovf    <= ovf | quo[QUO_W-1];
        if (count == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          count <= count - 1'b1;
        end
      end
    end
  end

  assign quotient = ovf ? '1 : quo;

  `FRM_ASSERT_NOW(a_div_no_restart, clk, rst, start, !busy)
  `FRM_ASSERT_NEXT(a_div_done_once, clk, rst, done, !done)
  `FRM_ASSERT_NOW(a_div_done_idle, clk, rst, done, !busy)

endmodule

/* src/frame_rate_meter_core.sv */
// Frame rate meter.
// Slave stream: one beat per frame carrying its timestamp (seconds and
// microseconds). The first beat after reset only primes the previous time.
// Each later beat counts a frame and adds the microsecond delta (clamped at
// zero on a backward step, saturating) to the elapsed total. When elapsed
// reaches window_us (APB register at address 0, 0 acts as 1), the rate
// frames*1e6/elapsed is recomputed in unsigned fixed point and the counters
// clear. Master stream: exactly one result beat per input beat.
// A beat that does not close a window steps through SCALE, OFFSET, ACCUM,
// CHECK and DONE, which loads m_tvalid; the first beat goes straight to
// DONE. A closing beat adds NUMER, LAUNCH and DIVIDE, a bit-serial
// restoring division, one quotient bit per cycle, over FRAME_COUNT_BITS +
// 20 + FRACTION_BITS bits (52 bits by default). s_tready is high only while
// the sequencer is idle, so no new beat is taken while one is in flight.
// The result sits in an output register; a new input beat is taken while it
// waits, and a stalled receiver holds the sequencer in its final step.
// Reset: window_us returns to 1000000, counters and the rate clear, and the
// next beat is again treated as the first.
module frame_rate_meter_core #(
  parameter int FRAME_COUNT_BITS = frm_pkg::FRAME_COUNT_BITS_DEF,
  parameter int FRACTION_BITS    = frm_pkg::FRACTION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // [31:0] time_seconds, [51:32] time_micros, [55:52] zero
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,
  // [0] rate_updated, [1] rate_changed, [26:2] rate_whole,
  // [58:27] rate_fixed, [63:59] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata
);
  import frm_pkg::*;

  `include "frame_rate_meter_core_macros.svh"

  localparam int FC_W  = FRAME_COUNT_BITS;
  localparam int PRD_W = FC_W + MICROS_W;
  localparam int NUM_W = PRD_W + FRACTION_BITS;
  localparam int ACC_W = SECS_W + MICROS_W + 2;
  localparam logic [RATE_W:0] HALF = (33'd1 << FRACTION_BITS) >> 1;
  localparam logic [ACC_W-1:0] ELAPSED_MAX = ACC_W'({ELAPSED_W{1'b1}});

  typedef enum logic [3:0] {
    IDLE, SCALE, OFFSET, ACCUM, CHECK, NUMER, LAUNCH, DIVIDE, DONE
  } state_t;

  function automatic logic [WHOLE_W-1:0] whole_of(input logic [RATE_W-1:0] q);
    logic [RATE_W:0] sum;
    sum = {1'b0, q} + HALF;
    return WHOLE_W'(sum >> FRACTION_BITS);
  endfunction

  state_t state;

  logic [WINDOW_W-1:0]  window_us;
  logic                 have_previous;
  logic [SECS_W-1:0]    previous_seconds;
  logic [MICROS_W-1:0]  previous_micros;
  logic [FC_W-1:0]      frame_count;
  logic [ELAPSED_W-1:0] elapsed_micros;
  logic [RATE_W-1:0]    rate_q;
  logic                 upd;
  logic                 chg;

  logic signed [SECS_W:0]    ds;
  logic signed [MICROS_W:0]  dus;
  logic signed [ACC_W-1:0]   prod;
  logic [ACC_W-2:0]          delta;
  logic [NUM_W-1:0]          numer;

  logic signed [ACC_W-1:0] prod_next;
  logic signed [ACC_W-1:0] delta_next;
  logic [ACC_W-1:0]        sum_next;
  logic [ELAPSED_W-1:0]    win;
  logic [PRD_W-1:0]        frames_scaled;

  logic                 cfg_wr;
  logic                 in_beat;
  logic                 div_start;
  logic                 div_done;
  logic [RATE_W-1:0]    div_quo;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_WINDOW_US);
  assign prdata   = (paddr[2] == REG_WINDOW_US) ? 32'(window_us) : '0;
  assign s_tready = (state == IDLE);
  assign in_beat  = s_tvalid && s_tready;
  assign div_start = (state == LAUNCH);

  always_comb begin
    prod_next     = ACC_W'(ds) * ACC_W'(21'sd1000000);
    delta_next    = prod + ACC_W'(dus);
    sum_next      = ACC_W'(elapsed_micros) + ACC_W'(delta);
    win           = (window_us == '0) ? ELAPSED_W'(1) : ELAPSED_W'(window_us);
    frames_scaled = PRD_W'(frame_count) * PRD_W'(MICROS_PER_SEC);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_us <= WINDOW_RESET;
    end else if (cfg_wr) begin
      window_us <= pwdata[WINDOW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= IDLE;
      have_previous    <= 1'b0;
      previous_seconds <= '0;
      previous_micros  <= '0;
      frame_count      <= '0;
      elapsed_micros   <= '0;
      rate_q           <= '0;
      upd              <= 1'b0;
      chg              <= 1'b0;
      m_tvalid         <= 1'b0;
    end else begin
      // DONE reloads the output register itself
      if (m_tvalid && m_tready && (state != DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (in_beat) begin
            ds  <= $signed({1'b0, s_tdata[31:0]}) - $signed({1'b0, previous_seconds});
            dus <= $signed({1'b0, s_tdata[51:32]}) - $signed({1'b0, previous_micros});
            previous_seconds <= s_tdata[31:0];
            previous_micros  <= s_tdata[51:32];
            upd <= 1'b0;
            chg <= 1'b0;
            if (have_previous) begin
              if (frame_count != '1) begin
                frame_count <= frame_count + 1'b1;
              end
              state <= SCALE;
            end else begin
              have_previous <= 1'b1;
              state         <= DONE;
            end
          end
        end
        SCALE: begin
          prod  <= prod_next;
          state <= OFFSET;
        end
        OFFSET: begin
          // clamp a backward step to zero
          delta <= delta_next[ACC_W-1] ? '0 : delta_next[ACC_W-2:0];
          state <= ACCUM;
        end
        ACCUM: begin
          elapsed_micros <= (sum_next > ELAPSED_MAX) ? '1 : sum_next[ELAPSED_W-1:0];
          state          <= CHECK;
        end
        CHECK: begin
          state <= (elapsed_micros >= win) ? NUMER : DONE;
        end
        NUMER: begin
          numer <= NUM_W'(frames_scaled) << FRACTION_BITS;
          state <= LAUNCH;
        end
        LAUNCH: begin
          state <= DIVIDE;
        end
        DIVIDE: begin
          if (div_done) begin
            rate_q         <= div_quo;
            upd            <= 1'b1;
            chg            <= (whole_of(div_quo) != whole_of(rate_q));
            frame_count    <= '0;
            elapsed_micros <= '0;
            state          <= DONE;
          end
        end
        DONE: begin
          // hold until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {5'b0, rate_q, whole_of(rate_q), chg, upd};
            state    <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  frm_divider #(
    .NUM_W (NUM_W),
    .DEN_W (ELAPSED_W),
    .QUO_W (RATE_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .numer    (numer),
    .denom    (elapsed_micros),
    .done     (div_done),
    .quotient (div_quo)
  );

  `FRM_ASSERT_NOW(a_changed_needs_update, clk, rst, m_tvalid, !(m_tdata[1] && !m_tdata[0]))
  `FRM_ASSERT_NOW(a_done_in_divide, clk, rst, div_done, state == DIVIDE)
  `FRM_ASSERT_NEXT(a_clear_after_update, clk, rst, (state == DIVIDE) && div_done,
                   (frame_count == '0) && (elapsed_micros == '0) && upd)

endmodule

/* dv/frame_rate_meter_checker.sv */
module frame_rate_meter_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [55:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [63:0] m_tdata,
  output int          pending,
  output int          failures
);
  timeunit 1ns;
  timeprecision 1ps;

  import frm_pkg::*;

  localparam int          COUNT_W     = FRAME_COUNT_BITS_DEF;
  localparam int          FRAC_W      = FRACTION_BITS_DEF;
  localparam logic [63:0] COUNT_TOP   = (64'd1 << COUNT_W) - 64'd1;
  localparam logic [63:0] ELAPSED_TOP = (64'd1 << ELAPSED_W) - 64'd1;

  typedef struct packed {
    logic               updated;
    logic               changed;
    logic [WHOLE_W-1:0] whole;
    logic [RATE_W-1:0]  fixed;
  } rate_report_t;

  rate_report_t rate_reports[$];

  logic [WINDOW_W-1:0] window;
  logic                seen_first;
  logic [SECS_W-1:0]   last_s;
  logic [MICROS_W-1:0] last_us;
  logic [63:0]         frames;
  logic [63:0]         elapsed;
  logic [RATE_W-1:0]   rate_q;

  // Floor of frames * 1e6 * 2^FRAC_W / span, clipped to the rate width.
  function automatic logic [RATE_W-1:0] fps_fixed(input logic [63:0] n_frames,
                                                  input logic [63:0] span);
    logic [63:0] num, quo, rem, frac, total;
    num = n_frames * 64'd1000000;
    quo = num / span;
    rem = num % span;
    if (quo > (64'hFFFF_FFFF >> FRAC_W)) return '1;
    frac  = (rem << FRAC_W) / span;
    total = (quo << FRAC_W) + frac;
    if (total > 64'hFFFF_FFFF) return '1;
    return total[RATE_W-1:0];
  endfunction

  function automatic logic [WHOLE_W-1:0] rounded_fps(input logic [RATE_W-1:0] q);
    logic [63:0] half, sum;
    half = (FRAC_W > 0) ? (64'd1 << (FRAC_W - 1)) : 64'd0;
    sum  = ({32'b0, q} + half) >> FRAC_W;
    return sum[WHOLE_W-1:0];
  endfunction

  function automatic rate_report_t meter_frame(input logic [SECS_W-1:0]   secs,
                                               input logic [MICROS_W-1:0] us);
    rate_report_t       rpt;
    longint             s_now, s_old, u_now, u_old, delta_us;
    logic [63:0]        gain, limit;
    logic [WHOLE_W-1:0] prior;
    rpt.updated = 1'b0;
    rpt.changed = 1'b0;
    if (!seen_first) begin
      seen_first = 1'b1;
    end else begin
      s_now    = secs;
      s_old    = last_s;
      u_now    = us;
      u_old    = last_us;
      delta_us = (s_now - s_old) * 1000000 + (u_now - u_old);
      // a step back in time adds nothing
      gain  = (delta_us < 0) ? 64'd0 : delta_us;
      limit = (window == '0) ? 64'd1 : {40'b0, window};
      if (frames != COUNT_TOP) frames = frames + 64'd1;
      if (gain > ELAPSED_TOP - elapsed) elapsed = ELAPSED_TOP;
      else elapsed = elapsed + gain;
      if (elapsed >= limit) begin
        prior       = rounded_fps(rate_q);
        rate_q      = fps_fixed(frames, elapsed);
        rpt.updated = 1'b1;
        rpt.changed = (rounded_fps(rate_q) != prior);
        frames      = '0;
        elapsed     = '0;
      end
    end
    last_s    = secs;
    last_us   = us;
    rpt.whole = rounded_fps(rate_q);
    rpt.fixed = rate_q;
    return rpt;
  endfunction

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin : watch
    rate_report_t want, got;
    if (rst) begin
      window     = WINDOW_RESET;
      seen_first = 1'b0;
      last_s     = '0;
      last_us    = '0;
      frames     = '0;
      elapsed    = '0;
      rate_q     = '0;
      failures   = 0;
      rate_reports.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.updated = m_tdata[0];
        got.changed = m_tdata[1];
        got.whole   = m_tdata[26:2];
        got.fixed   = m_tdata[58:27];
        if (rate_reports.size() == 0) begin
          $display("%0t: result beat with nothing expected, got %h", $time, m_tdata);
          failures++;
        end else begin
          want = rate_reports.pop_front();
          check_field("rate_updated", want.updated, got.updated);
          check_field("rate_changed", want.changed, got.changed);
          check_field("rate_whole", want.whole, got.whole);
          check_field("rate_fixed", want.fixed, got.fixed);
        end
        if (m_tdata[63:59] !== '0) begin
          $display("%0t: pad bits mismatch, expected 0, got %h", $time, m_tdata[63:59]);
          failures++;
        end
      end
      if (psel && penable && pready && paddr[2] == REG_WINDOW_US) begin
        if (pwrite) begin
          window = pwdata[WINDOW_W-1:0];
        end else begin
          check_field("window_us readback", {8'b0, window}, prdata);
        end
      end
      if (s_tvalid && s_tready) begin
        rate_reports.push_back(meter_frame(s_tdata[31:0], s_tdata[51:32]));
      end
    end
    pending <= rate_reports.size();
  end

endmodule

/* dv/frame_rate_meter_core_test.sv */
module frame_rate_meter_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         STALL_LIMIT = 4000;
  localparam int         PHASES      = 8;
  localparam int         PHASE_BEATS = 140;
  localparam logic [2:0] WINDOW_ADDR = {frm_pkg::REG_WINDOW_US, 2'b00};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // [31:0] time_seconds, [51:32] time_micros, [55:52] zero
  logic [55:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // [0] rate_updated, [1] rate_changed, [26:2] rate_whole, [58:27] rate_fixed
  logic [63:0] m_tdata;

  int pending;
  int failures;
  int dead_cycles = 0;
  int rx_beats = 0;
  bit no_idling = 1'b0;

  // running timestamp for the random part
  logic [31:0] t_s;
  logic [19:0] t_us;

  frame_rate_meter_core uut (
    .clk, .rst,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata
  );

  frame_rate_meter_checker rate_check (
    .clk, .rst,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata,
    .pending, .failures
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (m_tvalid && m_tready) rx_beats <= rx_beats + 1;
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      dead_cycles <= 0;
    end else if (dead_cycles == STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      dead_cycles <= dead_cycles + 1;
    end
  end

  // Receiver: random stall bursts, plus one long hold-off so the block backs up.
  initial begin : receiver
    bit long_done;
    long_done = 1'b0;
    @(negedge clk);
    forever begin
      if (!long_done && rx_beats >= 300) begin
        long_done = 1'b1;
        m_tready <= 1'b0;
        repeat (240) @(negedge clk);
      end else if (!no_idling && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // Called and returns at a falling edge; tvalid stays high for back-to-back beats.
  task automatic send_frame(input logic [31:0] secs, input logic [19:0] us);
    if (!no_idling && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, us, secs};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Drain every outstanding result before touching the register.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Write the window, then read it back.
  task automatic program_window(input logic [31:0] raw);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= WINDOW_ADDR;
    pwdata  <= raw;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic advance_time(input int unsigned span);
    logic [63:0] tot;
    tot  = 64'(t_us) + 64'(span);
    t_s  = t_s + 32'(tot / 64'd1000000);
    t_us = 20'(tot % 64'd1000000);
  endtask

  task automatic random_run(input int unsigned win, input int unsigned beats);
    int unsigned sent, pick, n, span;
    sent = 0;
    while (sent < beats) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        // step back in time
        t_s  = t_s - $urandom_range(0, 2);
        t_us = 20'($urandom_range(0, 999999));
        send_frame(t_s, t_us);
        sent++;
      end else if (pick < 13) begin
        t_s  = $urandom;
        t_us = 20'($urandom_range(0, 999999));
        send_frame(t_s, t_us);
        sent++;
      end else if (pick < 18) begin
        // microsecond part past a whole second
        send_frame(t_s, 20'($urandom_range(1000000, 20'hFFFFF)));
        sent++;
      end else if (pick < 30) begin
        // repeated timestamps pile up frames with no elapsed time
        n = $urandom_range(1, 24);
        repeat (n) send_frame(t_s, t_us);
        sent += n;
      end else begin
        span = $urandom_range(0, (win * $urandom_range(1, 3)) / $urandom_range(1, 8));
        advance_time(span);
        send_frame(t_s, t_us);
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    logic [31:0] raws [PHASES];
    int unsigned win;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // default window: priming, closing, backward step, oversized micros, huge jump
    send_frame(32'd0, 20'd0);
    send_frame(32'd0, 20'd999999);
    send_frame(32'd1, 20'd0);
    send_frame(32'd0, 20'd5);
    send_frame(32'd0, 20'hFFFFF);
    send_frame(32'hFFFF_FFFF, 20'd999999);
    send_frame(32'd0, 20'd0);

    // one-microsecond window: many frames over one microsecond clip the rate
    drain_results();
    program_window(32'd1);
    repeat (17) send_frame(32'd0, 20'd0);
    send_frame(32'd0, 20'd1);
    send_frame(32'd0, 20'd2);
    t_s  = 32'd0;
    t_us = 20'd2;

    raws = '{32'd1, 32'hA500_0000, 32'h00FF_FFFF, 32'd1000000, 32'd0, 32'd0, 32'd0, 32'd0};
    raws[4] = $urandom_range(2, 5000) | ($urandom & 32'hFF00_0000);
    raws[5] = $urandom_range(5000, 16777214);
    raws[6] = $urandom_range(2, 200);
    raws[7] = $urandom_range(100000, 3000000);
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      program_window(raws[p]);
      win = (raws[p][23:0] == 24'd0) ? 1 : raws[p][23:0];
      if (p == PHASES - 1) no_idling = 1'b1;
      random_run(win, PHASE_BEATS);
    end

    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (failures == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/frm_pkg.sv
src/frm_divider.sv
src/frame_rate_meter_core.sv
dv/frame_rate_meter_checker.sv
dv/frame_rate_meter_core_test.sv
